@@ rtl/abal_pkg.sv @@
// Block allocator package: table size, field widths, mark codes, sequencer
// states and the result struct. No dependencies.
package abal_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);
   localparam int PTR_W      = ADDR_W + 1;
   localparam int END_W      = ADDR_W + 2;
   localparam int COUNT_W    = 11;
   localparam int SLOT_W     = 10;
   localparam int MARK_W     = 2;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef enum logic [MARK_W-1:0] {
      MARK_FREE = 2'd0,
      MARK_HEAD = 2'd1,
      MARK_CONT = 2'd2
   } mark_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AREAD,
      ST_ACHECK,
      ST_MARK,
      ST_RWRITE,
      ST_RREAD,
      ST_RCHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              ok;
   } rsp_type;

endpackage

@@ rtl/abal_req_if.sv @@
// Request channel: valid/ready handshake with action, block count and slot.
// Depends on abal_pkg.
interface abal_req_if import abal_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [COUNT_W-1:0] block_count;
   logic [SLOT_W-1:0]  slot_index;

   modport source (output valid, action, block_count, slot_index, input ready);
   modport sink   (input valid, action, block_count, slot_index, output ready);
endinterface

@@ rtl/abal_rsp_if.sv @@
// Response channel: valid/ready handshake with allocated slot and ok flag.
// Depends on abal_pkg.
interface abal_rsp_if import abal_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic              ok;

   modport source (output valid, slot, ok, input ready);
   modport sink   (input valid, slot, ok, output ready);
endinterface

@@ rtl/abal_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module abal_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/abal_rsp_stage.sv @@
// Response holding register between the sequencer and the response channel.
// Depends on abal_pkg and abal_rsp_if.
module abal_rsp_stage import abal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type result,
   output logic    out_free,
   abal_rsp_if.source rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      out_free = !valid_ff || rsp.ready;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp.ready) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.slot  = data_ff.slot;
   assign rsp.ok    = data_ff.ok;

endmodule

@@ rtl/abal_ctrl.sv @@
// Allocation sequencer: clears the mark table, scans candidates, marks runs
// and frees runs through the mark RAM. Depends on abal_pkg and abal_req_if.
module abal_ctrl import abal_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               mode,
   abal_req_if.sink           req,
   output logic               push,
   output rsp_type            result,
   input  logic               out_free,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [MARK_W-1:0]  wr_data,
   output logic               rd_en,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [MARK_W-1:0]  rd_data
);

   localparam logic [END_W-1:0] NUM_END   = END_W'(NUM_BLOCKS);
   localparam logic [PTR_W-1:0] HALF_PTR  = PTR_W'(NUM_BLOCKS / 2);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(NUM_BLOCKS - 1);

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [PTR_W-1:0]   cand_ff, cand_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               ok_ff, ok_in;

   logic [PTR_W-1:0]   start;
   logic [END_W-1:0]   start_end;
   logic [END_W-1:0]   cand_end;
   logic [END_W-1:0]   ptr_next;
   mark_type           rd_mark;

   assign start     = mode ? HALF_PTR : '0;
   assign start_end = END_W'(start) + END_W'(req.block_count);
   assign cand_end  = END_W'(cand_ff) + END_W'(count_ff);
   assign ptr_next  = END_W'(ptr_ff) + END_W'(1);
   assign rd_mark   = mark_type'(rd_data);
   assign result    = '{slot: slot_ff, ok: ok_ff};

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cand_in   = cand_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      ok_in     = ok_ff;
      req.ready = 1'b0;
      push      = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[ADDR_W-1:0];
      wr_data   = MARK_FREE;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[ADDR_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_next[PTR_W-1:0];
            if (ptr_ff == LAST_PTR) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               slot_in  = '0;
               ok_in    = 1'b1;
               count_in = req.block_count;
               if (req.action == ACT_ALLOC) begin
                  ok_in   = 1'b0;
                  cand_in = start;
                  ptr_in  = start;
                  if (req.block_count == '0 || start_end > NUM_END) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_AREAD;
                  end
               end else begin
                  ptr_in = PTR_W'(req.slot_index);
                  if (END_W'(req.slot_index) >= NUM_END) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_RWRITE;
                  end
               end
            end
         end
         ST_AREAD: begin
            rd_en    = 1'b1;
            state_in = ST_ACHECK;
         end
         ST_ACHECK: begin
            if (rd_mark != MARK_FREE) begin
               cand_in = cand_end[PTR_W-1:0];
               ptr_in  = cand_end[PTR_W-1:0];
               if (cand_end + END_W'(count_ff) > NUM_END) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_AREAD;
               end
            end else if (ptr_next == cand_end) begin
               ptr_in   = cand_ff;
               state_in = ST_MARK;
            end else begin
               ptr_in   = ptr_next[PTR_W-1:0];
               state_in = ST_AREAD;
            end
         end
         ST_MARK: begin
            wr_en   = 1'b1;
            wr_data = (ptr_ff == cand_ff) ? MARK_HEAD : MARK_CONT;
            ptr_in  = ptr_next[PTR_W-1:0];
            if (ptr_next == cand_end) begin
               slot_in  = cand_ff[SLOT_W-1:0];
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_RWRITE: begin
            wr_en  = 1'b1;
            ptr_in = ptr_next[PTR_W-1:0];
            if (ptr_next >= NUM_END) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RREAD;
            end
         end
         ST_RREAD: begin
            rd_en    = 1'b1;
            state_in = ST_RCHECK;
         end
         ST_RCHECK: begin
            if (rd_mark == MARK_CONT) begin
               wr_en  = 1'b1;
               ptr_in = ptr_next[PTR_W-1:0];
               if (ptr_next >= NUM_END) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RREAD;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
      cand_ff  <= cand_in;
      count_ff <= count_in;
      slot_ff  <= slot_in;
      ok_ff    <= ok_in;
   end

   a_acheck_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACHECK |-> $past(state_ff) == ST_AREAD)
      else $error("mark check without a preceding read");

   a_rcheck_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RCHECK |-> $past(state_ff) == ST_RREAD)
      else $error("release check without a preceding read");

   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> ptr_ff >= cand_ff && END_W'(ptr_ff) < cand_end)
      else $error("mark write outside the chosen run");

   a_run_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACHECK || state_ff == ST_MARK) |-> cand_end <= NUM_END)
      else $error("candidate run passes the table end");

endmodule

@@ rtl/aligned_block_allocator_top.sv @@
// Aligned block allocator: first-fit, size-aligned allocation over a
// 1024-entry mark table held in a synchronous RAM; one request at a time.
// After reset the table is cleared one entry per cycle, with req_chan.ready
// low. An allocate reads each table entry it tests through the single RAM
// read port (RAM read, then check) and then writes a mark for each block of
// the run. A release frees the head entry, then reads and frees each
// following continued block in turn. The response sits in an output
// register, so the next request is taken while it waits.
// Depends on abal_pkg, abal_req_if, abal_rsp_if, abal_ram, abal_ctrl,
// abal_rsp_stage.
module aligned_block_allocator_top import abal_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   abal_req_if.sink   req_chan,
   abal_rsp_if.source rsp_chan
);

   logic              mode_ff, mode_in;
   logic              push;
   logic              out_free;
   rsp_type           result;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [MARK_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [MARK_W-1:0] rd_data;

   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   abal_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .req      (req_chan),
      .push     (push),
      .result   (result),
      .out_free (out_free),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   abal_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (MARK_W)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   abal_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .result   (result),
      .out_free (out_free),
      .rsp      (rsp_chan)
   );

endmodule

@@ sim/tb_aligned_block_allocator_top.sv @@
// Testbench for aligned_block_allocator_top: directed and random allocate and
// release transfers, checked against an in-bench shadow of the block table.
// Depends on abal_pkg, abal_req_if, abal_rsp_if and the allocator RTL.
module tb_aligned_block_allocator_top;
   import abal_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 3200;
   localparam int PRINT_LIMIT  = 40;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   abal_req_if req_chan ();
   abal_rsp_if rsp_chan ();

   aligned_block_allocator_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   mark_type shadow_marks [NUM_BLOCKS];
   bit       shadow_bitmapped;
   rsp_type  pending_results [$];
   int       mismatch_count;
   int       stall_cycles;
   int       burst_left;
   bit       sender_no_gaps;
   bit       hold_request;
   bit       hold_active;
   int       live_heads [$];
   int       used_blocks;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type predict_slot(input logic act,
                                            input logic [COUNT_W-1:0] count,
                                            input logic [SLOT_W-1:0] index);
      rsp_type result;
      int      start;
      int      j;
      bit      fits;
      result = '0;
      if (act == ACT_RELEASE) begin
         result.ok = 1'b1;
         if (int'(index) < NUM_BLOCKS) begin
            shadow_marks[index] = MARK_FREE;
            j = int'(index) + 1;
            while (j < NUM_BLOCKS && shadow_marks[ADDR_W'(j)] == MARK_CONT) begin
               shadow_marks[ADDR_W'(j)] = MARK_FREE;
               j++;
            end
         end
      end else if (count != '0) begin
         start = shadow_bitmapped ? NUM_BLOCKS / 2 : 0;
         while (start < NUM_BLOCKS && !result.ok) begin
            fits = (start + int'(count) <= NUM_BLOCKS);
            for (j = 0; fits && j < int'(count); j++)
               if (shadow_marks[ADDR_W'(start + j)] != MARK_FREE) fits = 1'b0;
            if (fits) begin
               shadow_marks[ADDR_W'(start)] = MARK_HEAD;
               for (j = 1; j < int'(count); j++)
                  shadow_marks[ADDR_W'(start + j)] = MARK_CONT;
               result.slot = start[SLOT_W-1:0];
               result.ok   = 1'b1;
            end else begin
               start += int'(count);
            end
         end
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_no_gaps ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_request(input logic act, input int count, input int index);
      rsp_type want;
      pace_sender();
      req_chan.valid       <= 1'b1;
      req_chan.action      <= act;
      req_chan.block_count <= count[COUNT_W-1:0];
      req_chan.slot_index  <= index[SLOT_W-1:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want = predict_slot(act, count[COUNT_W-1:0], index[SLOT_W-1:0]);
      pending_results.push_back(want);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input bit value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_bitmapped = value;
      @(posedge clock);
   endtask

   task automatic change_mode(input bit value);
      wait_drained();
      repeat (4) @(posedge clock);
      write_mode(value);
   endtask

   task automatic clear_table();
      int i;
      for (i = 0; i < NUM_BLOCKS; i++)
         if (shadow_marks[ADDR_W'(i)] == MARK_HEAD)
            send_request(ACT_RELEASE, $urandom_range(0, 2047), i);
   endtask

   task automatic test_field_extremes();
      send_request(ACT_ALLOC, 0, 0);
      send_request(ACT_ALLOC, 2047, 1023);
      send_request(ACT_ALLOC, 1025, 0);
      send_request(ACT_ALLOC, 1024, 0);
      send_request(ACT_ALLOC, 1, 1023);
      send_request(ACT_RELEASE, 2047, 0);
      send_request(ACT_ALLOC, 1, 0);
      send_request(ACT_RELEASE, 0, 1023);
      send_request(ACT_RELEASE, 0, 0);
   endtask

   task automatic test_partial_release();
      send_request(ACT_ALLOC, 8, 0);
      send_request(ACT_RELEASE, 0, 3);
      send_request(ACT_ALLOC, 4, 0);
      send_request(ACT_ALLOC, 2, 0);
      send_request(ACT_RELEASE, 0, 0);
      send_request(ACT_ALLOC, 512, 0);
      send_request(ACT_RELEASE, 0, 1023);
      send_request(ACT_RELEASE, 0, 512);
      clear_table();
   endtask

   task automatic test_bitmapped_mode();
      change_mode(1'b1);
      send_request(ACT_ALLOC, 1, 0);
      send_request(ACT_ALLOC, 512, 0);
      send_request(ACT_ALLOC, 256, 0);
      send_request(ACT_ALLOC, 1024, 0);
      send_request(ACT_ALLOC, 2, 0);
      clear_table();
      change_mode(1'b0);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      sender_no_gaps = 1'b1;
      repeat (10) send_request(ACT_ALLOC, $urandom_range(1, 16), $urandom_range(0, 1023));
      sender_no_gaps = 1'b0;
      wait_drained();
      clear_table();
   endtask

   task automatic random_item();
      int pick;
      int sel;
      int count;
      int i;
      live_heads.delete();
      used_blocks = 0;
      for (i = 0; i < NUM_BLOCKS; i++) begin
         if (shadow_marks[ADDR_W'(i)] == MARK_HEAD) live_heads.push_back(i);
         if (shadow_marks[ADDR_W'(i)] != MARK_FREE) used_blocks++;
      end
      pick = $urandom_range(0, 99);
      if (live_heads.size() != 0 && (pick < 35 || used_blocks > 600)) begin
         send_request(ACT_RELEASE, $urandom_range(0, 2047),
                      live_heads[$urandom_range(0, live_heads.size() - 1)]);
      end else if (pick < 42) begin
         send_request(ACT_RELEASE, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 55) count = $urandom_range(1, 8);
         else if (sel < 80) count = $urandom_range(9, 64);
         else if (sel < 88) count = $urandom_range(65, 512);
         else if (sel < 92) count = $urandom_range(513, 1024);
         else if (sel < 96) count = $urandom_range(1025, 2047);
         else count = 0;
         send_request(ACT_ALLOC, count, $urandom_range(0, 1023));
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 4; phase++) begin
         change_mode(phase[0]);
         sender_no_gaps = (phase == 2);
         repeat (140) random_item();
      end
      sender_no_gaps = 1'b0;
   endtask

   // receiver: random stall pattern, long hold on request
   initial begin
      int style;
      int len;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            style = $urandom_range(0, 3);
            len   = $urandom_range(1, 24);
            repeat (len) begin
               case (style)
                  0: rsp_chan.ready <= 1'b1;
                  1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_chan.ready <= 1'($urandom_range(0, 1));
                  default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer, slot", int'(rsp_chan.slot), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.slot !== want.slot)
               report_mismatch("slot", int'(rsp_chan.slot), int'(want.slot));
            if (rsp_chan.ok !== want.ok)
               report_mismatch("ok", int'(rsp_chan.ok), int'(want.ok));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int i;
      for (i = 0; i < NUM_BLOCKS; i++) shadow_marks[ADDR_W'(i)] = MARK_FREE;
      shadow_bitmapped = 1'b0;
      mismatch_count   = 0;
      burst_left       = 0;
      sender_no_gaps   = 1'b0;
      hold_request     = 1'b0;
      hold_active      = 1'b0;
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_write_data       <= 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACT_ALLOC;
      req_chan.block_count <= '0;
      req_chan.slot_index  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b1);
      write_mode(1'b0);

      test_field_extremes();
      test_partial_release();
      test_bitmapped_mode();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
